// File: design/sddw_pkg.sv
// ----------------------------------------------------------------------------
// sddw_pkg - shared definitions for the signed decimal display writer
// Field widths, display codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package sddw_pkg;

  // Default number of display positions
  localparam int MaxDigitsDefault = 8;

  // Fixed field widths
  localparam int ValueW = 28;
  localparam int MagW   = 27;   // holds 10^8 - 1
  localparam int AddrW  = 4;
  localparam int CodeW  = 4;
  localparam int QuotW  = 24;   // (2^27 - 1) / 10 fits in 24 bits

  // Code-B driver values
  localparam logic [CodeW-1:0] CodeBlank = 4'hF;
  localparam logic [CodeW-1:0] CodeMinus = 4'hA;

  // Reset value of the digits-in-use register
  localparam logic [3:0] DigitsInUseReset = 4'd4;

  // Reciprocal of ten, exact for any 32-bit dividend with a shift of 35
  localparam logic [31:0] Div10Recip = 32'hCCCC_CCCD;
  localparam int          Div10Shift = 35;

  // Power of ten, worked out at elaboration
  function automatic int pow10(input int e);
    int p;
    p = 1;
    for (int k = 0; k < e; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a new value
    logic step;   // drop the lowest decimal digit
  } sddw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CodeW-1:0] digit;      // lowest decimal digit of the magnitude
    logic             quot_zero;  // nothing left after this digit
    logic             neg;        // value is negative
    logic [AddrW-1:0] blanks;     // positions to blank, clamped
  } sddw_status_t;

endpackage

// File: design/sddw_datapath.sv
// ----------------------------------------------------------------------------
// sddw_datapath - value saturation, magnitude register and digit extraction
// Holds the digits-in-use register and peels one decimal digit per step.
// ----------------------------------------------------------------------------
module sddw_datapath #(
  parameter int MAX_DIGITS = sddw_pkg::MaxDigitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [sddw_pkg::ValueW-1:0]    value_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [3:0]                            cfg_data_i,
  input  sddw_pkg::sddw_cmd_t                   cmd_i,
  output sddw_pkg::sddw_status_t                status_o
);

  localparam logic signed [sddw_pkg::ValueW-1:0] SatHi =
    sddw_pkg::ValueW'(sddw_pkg::pow10(MAX_DIGITS) - 1);
  localparam logic signed [sddw_pkg::ValueW-1:0] SatLo =
    sddw_pkg::ValueW'(-(sddw_pkg::pow10(MAX_DIGITS - 1) - 1));
  localparam logic [sddw_pkg::AddrW-1:0] MaxPos = sddw_pkg::AddrW'(MAX_DIGITS);
  localparam int ProdW = sddw_pkg::MagW + 32;

  logic [3:0]                         cfg_q;
  logic [sddw_pkg::AddrW-1:0]         blanks;
  logic [sddw_pkg::MagW-1:0]          mag_q, mag_d;
  logic                               neg_q, neg_d;
  logic signed [sddw_pkg::ValueW-1:0] sat;
  logic signed [sddw_pkg::ValueW-1:0] abs_val;
  logic [ProdW-1:0]                   prod;
  logic [sddw_pkg::QuotW-1:0]         quot;
  logic [sddw_pkg::MagW-1:0]          quot_x10;
  logic [sddw_pkg::MagW-1:0]          rem;

  // Accept every configuration beat
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sddw_pkg::DigitsInUseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Clamp the blank count into 1..MAX_DIGITS
  always_comb begin
    if (cfg_q == 4'd0) begin
      blanks = sddw_pkg::AddrW'(1);
    end else if (cfg_q > MaxPos) begin
      blanks = MaxPos;
    end else begin
      blanks = cfg_q;
    end
  end

  // Saturate the input and take its magnitude
  always_comb begin
    if (value_i > SatHi) begin
      sat = SatHi;
    end else if (value_i < SatLo) begin
      sat = SatLo;
    end else begin
      sat = value_i;
    end
    abs_val = sat[sddw_pkg::ValueW-1] ? -sat : sat;
  end

  // Divide by ten through the reciprocal, then form the remainder
  assign prod     = ProdW'(mag_q) * ProdW'(sddw_pkg::Div10Recip);
  assign quot     = prod[sddw_pkg::Div10Shift +: sddw_pkg::QuotW];
  assign quot_x10 = sddw_pkg::MagW'({quot, 3'b000}) + sddw_pkg::MagW'({quot, 1'b0});
  assign rem      = mag_q - quot_x10;

  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      mag_d = abs_val[sddw_pkg::MagW-1:0];
      neg_d = sat[sddw_pkg::ValueW-1];
    end else if (cmd_i.step) begin
      mag_d = sddw_pkg::MagW'(quot);
    end
  end

  // Hold the magnitude and sign between steps
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  assign status_o.blanks    = blanks;
  assign status_o.digit     = rem[sddw_pkg::CodeW-1:0];
  assign status_o.quot_zero = (quot == '0);
  assign status_o.neg       = neg_q;

endmodule

// File: design/sddw_ctrl.sv
// ----------------------------------------------------------------------------
// sddw_ctrl - write sequencer for the signed decimal display writer
// Walks blanks, digits and the minus sign, one register write per cycle.
// ----------------------------------------------------------------------------
module sddw_ctrl #(
  parameter int MAX_DIGITS = sddw_pkg::MaxDigitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  output sddw_pkg::sddw_cmd_t             cmd_o,
  input  sddw_pkg::sddw_status_t          status_i,
  output logic                            strobe_o,
  output logic [sddw_pkg::AddrW-1:0]      register_address_o,
  output logic [sddw_pkg::CodeW-1:0]      digit_code_o,
  output logic                            last_write_o
);

  typedef enum logic [1:0] {
    StIdle,
    StBlank,
    StDigit,
    StMinus
  } state_e;

  localparam logic [sddw_pkg::AddrW-1:0] PosOne = sddw_pkg::AddrW'(1);
  localparam logic [sddw_pkg::AddrW-1:0] MaxPos = sddw_pkg::AddrW'(MAX_DIGITS);

  state_e                       state_q;
  logic [sddw_pkg::AddrW-1:0]   pos_q;
  logic                         strobe_q;
  logic [sddw_pkg::AddrW-1:0]   addr_q;
  logic [sddw_pkg::CodeW-1:0]   code_q;
  logic                         last_q;

  assign busy        = (state_q != StIdle);
  assign cmd_o.load  = start && (state_q == StIdle);
  assign cmd_o.step  = (state_q == StDigit);

  // Advance the sequence and register one write beat per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pos_q    <= PosOne;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      addr_q   <= PosOne;
      code_q   <= sddw_pkg::CodeBlank;
    end else begin
      case (state_q)
        StIdle: begin
          strobe_q <= start;
          last_q   <= 1'b0;
          if (start) begin
            addr_q   <= status_i.blanks;
            code_q   <= sddw_pkg::CodeBlank;
            if (status_i.blanks == PosOne) begin
              state_q <= StDigit;
              pos_q   <= PosOne;
            end else begin
              state_q <= StBlank;
              pos_q   <= status_i.blanks - PosOne;
            end
          end
        end
        StBlank: begin
          strobe_q <= 1'b1;
          last_q   <= 1'b0;
          addr_q   <= pos_q;
          code_q   <= sddw_pkg::CodeBlank;
          if (pos_q == PosOne) begin
            state_q <= StDigit;
          end else begin
            pos_q <= pos_q - PosOne;
          end
        end
        StDigit: begin
          strobe_q <= 1'b1;
          last_q   <= status_i.quot_zero && !status_i.neg;
          addr_q   <= pos_q;
          code_q   <= status_i.digit;
          pos_q    <= pos_q + PosOne;
          if (status_i.quot_zero) begin
            if (status_i.neg) begin
              state_q <= StMinus;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StMinus: begin
          strobe_q <= 1'b1;
          addr_q   <= pos_q;
          code_q   <= sddw_pkg::CodeMinus;
          last_q   <= 1'b1;
          state_q  <= StIdle;
        end
        default: begin
          strobe_q <= 1'b0;
          last_q   <= 1'b0;
          state_q  <= StIdle;
        end
      endcase
    end
  end

  assign strobe_o           = strobe_q;
  assign register_address_o = addr_q;
  assign digit_code_o       = code_q;
  assign last_write_o       = last_q;

  // Every busy cycle issues a write beat on the next cycle
  a_busy_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |=> strobe_q)
    else $error("busy cycle without a write beat");

  // The final marker only rides on a write beat
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> strobe_q)
    else $error("last write flagged without a beat");

  // Addresses stay inside the display
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> ((addr_q >= PosOne) && (addr_q <= MaxPos)))
    else $error("write address outside the display");

  // A blank is never the final write
  a_blank_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && (code_q == sddw_pkg::CodeBlank)) |-> !last_q)
    else $error("blank flagged as last write");

endmodule

// File: design/signed_decimal_display_writer.sv
// ----------------------------------------------------------------------------
// signed_decimal_display_writer - signed integer to code-B digit writes
// The first write beat is registered and appears in the cycle after start is taken.
// Each value gives N write beats, N = blanks + digits (+1 for minus), N <= 16;
//   the sequencer issues one write beat per cycle, one digit per step.
// busy falls in the cycle that shows the last write beat; the receiver cannot stall.
// Reset clears the sequencer and loads digits-in-use with 4.
// ----------------------------------------------------------------------------
module signed_decimal_display_writer #(
  parameter int MAX_DIGITS = sddw_pkg::MaxDigitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sddw_pkg::ValueW-1:0]  value_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [3:0]                          cfg_data_i,
  output logic                                strobe_o,
  output logic [sddw_pkg::AddrW-1:0]          register_address_o,
  output logic [sddw_pkg::CodeW-1:0]          digit_code_o,
  output logic                                last_write_o
);

  sddw_pkg::sddw_cmd_t    cmd;
  sddw_pkg::sddw_status_t status;

  // Sequencer
  sddw_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_o              (cmd),
    .status_i           (status),
    .strobe_o           (strobe_o),
    .register_address_o (register_address_o),
    .digit_code_o       (digit_code_o),
    .last_write_o       (last_write_o)
  );

  // Value and configuration datapath
  sddw_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the signed decimal display writer
// Drives signed values through the start/busy command port, predicts the
// blank, digit and minus register writes for each one, and compares every
// strobed write beat in order. The digits-in-use register is changed between
// drained phases, including the clamped settings at both ends.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Digits  = sddw_pkg::MaxDigitsDefault;
  localparam int ValueW  = sddw_pkg::ValueW;
  localparam int AddrW   = sddw_pkg::AddrW;
  localparam int CodeW   = sddw_pkg::CodeW;
  localparam logic [CodeW-1:0] CodeBlank = sddw_pkg::CodeBlank;
  localparam logic [CodeW-1:0] CodeMinus = sddw_pkg::CodeMinus;
  localparam logic [3:0] DigitsInUseReset = sddw_pkg::DigitsInUseReset;
  localparam int ValueHi = 99_999_999;   // eight nines
  localparam int ValueLo = -9_999_999;   // seven nines, room for the minus

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [CodeW-1:0] code;
    logic             last;
  } display_write_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic signed [ValueW-1:0]  value_i;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [3:0]                cfg_data_i;
  logic                      strobe_o;
  logic [AddrW-1:0]          register_address_o;
  logic [CodeW-1:0]          digit_code_o;
  logic                      last_write_o;

  display_write_t pending_writes[$];
  logic [3:0]     digits_in_use_model;
  logic [15:0]    settings_seen;
  int             mismatches;
  int             writes_checked;
  int             values_sent;

  signed_decimal_display_writer #(
    .MAX_DIGITS(Digits)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .value_i            (value_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .strobe_o           (strobe_o),
    .register_address_o (register_address_o),
    .digit_code_o       (digit_code_o),
    .last_write_o       (last_write_o)
  );

  always #10 clk_i = ~clk_i;

  // Work out the write beats one value causes under the current setting
  function automatic void predict_display_writes(input logic signed [ValueW-1:0] v);
    int          val;
    int unsigned mag;
    int          blanks;
    int          pos;
    bit          neg;
    val = v;
    if (val > ValueHi) val = ValueHi;
    if (val < ValueLo) val = ValueLo;
    neg = (val < 0);
    mag = neg ? -val : val;
    blanks = digits_in_use_model;
    if (blanks == 0) blanks = 1;
    if (blanks > Digits) blanks = Digits;
    for (pos = blanks; pos >= 1; pos--) begin
      pending_writes.push_back('{addr: pos[AddrW-1:0], code: CodeBlank, last: 1'b0});
    end
    if (mag == 0) begin
      pending_writes.push_back('{addr: 4'd1, code: 4'd0, last: 1'b0});
    end else begin
      pos = 0;
      while (mag != 0) begin
        pos++;
        pending_writes.push_back('{addr: pos[AddrW-1:0], code: 4'(mag % 10), last: 1'b0});
        mag = mag / 10;
      end
      if (neg) begin
        pending_writes.push_back('{addr: 4'(pos + 1), code: CodeMinus, last: 1'b0});
      end
    end
    pending_writes[pending_writes.size() - 1].last = 1'b1;
  endfunction

  // Compare each strobed write beat with the oldest expected one
  always @(posedge clk_i) begin
    display_write_t exp_w;
    if (rst_ni && strobe_o) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: unexpected write beat addr=%0d code=%0d last=%0b",
                   register_address_o, digit_code_o, last_write_o);
        end
      end else begin
        exp_w = pending_writes.pop_front();
        writes_checked++;
        if (exp_w.addr !== register_address_o || exp_w.code !== digit_code_o ||
            exp_w.last !== last_write_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: mismatch addr/code/last exp %0d/%0d/%0b got %0d/%0d/%0b",
                     exp_w.addr, exp_w.code, exp_w.last,
                     register_address_o, digit_code_o, last_write_o);
          end
        end
      end
    end
  end

  // Offer one value and hold start high until the beat is taken
  task automatic send_value(input logic signed [ValueW-1:0] v);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    predict_display_writes(v);
    values_sent++;
  endtask

  // Drop start for a short burst
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and wait for every expected write beat to arrive
  task automatic drain_writes();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the digits-in-use register while the block is idle
  task automatic set_digits_in_use(input logic [3:0] d);
    drain_writes();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    digits_in_use_model = d;
    settings_seen[d]    = 1'b1;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [ValueW-1:0] random_value();
    int t;
    case ($urandom_range(0, 9))
      0, 1:    t = $urandom_range(0, 99);
      2, 3:    t = $urandom_range(0, ValueHi);
      4:       t = -int'($urandom_range(1, -ValueLo));
      5:       t = $urandom;
      6:       t = ValueHi + 1 - int'($urandom_range(0, 2));
      7:       t = ValueLo + 1 - int'($urandom_range(0, 2));
      default: t = $urandom_range(0, 9999);
    endcase
    if ($urandom_range(0, 3) == 0 && t > 0 && t <= 9999) t = -t;
    return t[ValueW-1:0];
  endfunction

  // Extremes of the value field under the reset setting
  task automatic test_value_extremes();
    int vals[$];
    vals = '{0, 1, -1, 9, 10, -10, 7, 12_345_678, -1_234_567, ValueHi, ValueHi + 1,
             ValueLo, ValueLo - 1, 134_217_727, -134_217_728};
    foreach (vals[i]) begin
      send_value(vals[i][ValueW-1:0]);
      if (i % 4 == 3) hold_off($urandom_range(1, 3));
    end
    drain_writes();
  endtask

  // Zero, the ends of the range and the clamped settings of the register
  task automatic test_digit_settings();
    logic [3:0] settings[5];
    settings = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15};
    foreach (settings[i]) begin
      set_digits_in_use(settings[i]);
      send_value(28'(-(i + 3) * 101));
      send_value(28'(ValueHi));
    end
  endtask

  // Random values across random settings, with random idling bursts
  task automatic test_random_values();
    bit idling;
    for (int blk = 0; blk < 7; blk++) begin
      set_digits_in_use(4'($urandom_range(0, 15)));
      idling = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 48; n++) begin
        send_value(random_value());
        if (idling && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 3));
        // pause once in the middle until everything is out
        if (blk == 3 && n == 20) drain_writes();
      end
    end
  endtask

  // Back-to-back values with no idling at the end of the run
  task automatic test_back_to_back();
    set_digits_in_use(4'd8);
    for (int n = 0; n < 60; n++) begin
      send_value(random_value());
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    start               <= 1'b0;
    value_i             <= '0;
    cfg_valid_i         <= 1'b0;
    cfg_data_i          <= '0;
    digits_in_use_model = DigitsInUseReset;
    settings_seen       = '0;
    mismatches          = 0;
    writes_checked      = 0;
    values_sent         = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_value_extremes();
    test_digit_settings();
    test_random_values();
    test_back_to_back();

    drain_writes();
    repeat (20) @(posedge clk_i);
    mismatches += pending_writes.size();

    $display("tb: %0d values sent, %0d write beats checked, %0d mismatches",
             values_sent, writes_checked, mismatches);
    $display("tb: digits-in-use settings used (bit per setting): %016b", settings_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
